@@ design/rpc_pkg.sv @@
`timescale 1ns / 1ps

package rpc_pkg;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_LEFT   = 2'd0;
	localparam cfg_idx_t REG_BOTTOM = 2'd1;
	localparam cfg_idx_t REG_RIGHT  = 2'd2;
	localparam cfg_idx_t REG_TOP    = 2'd3;

	// half-plane selection of a clip cell, in chain order
	localparam int unsigned EDGE_LEFT   = 0;
	localparam int unsigned EDGE_RIGHT  = 1;
	localparam int unsigned EDGE_BOTTOM = 2;
	localparam int unsigned EDGE_TOP    = 3;
	localparam int unsigned NUM_CELLS   = 4;

	// control part of a vertex link between cells
	typedef struct packed {
		logic valid;
		logic close;
	} link_ctl_t;

endpackage

@@ design/rect_polygon_clip.sv @@
`timescale 1ns / 1ps
// channel   valid / ready              payload
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
// vertex    vertex_valid / vertex_ready vertex_x, vertex_y, polygon_end
// clip      clip_valid / clip_ready    clipped_x, clipped_y, ring_end, ring_empty
//
// A cell that computes a crossing point uses its serial multiply-divide unit, which
// sets the rate on edges that cross a window side.
// Reset clears all control state and the window registers to zero.
// Stalls on clip_ready back up through the cell chain to vertex_ready.

module rect_polygon_clip import rpc_pkg::*; #(
	parameter int unsigned COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  cfg_idx_t                     cfg_index,
	input  logic signed [COORD_BITS-1:0] cfg_data,
	input  logic                         vertex_valid,
	output logic                         vertex_ready,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic                         polygon_end,
	output logic                         clip_valid,
	input  logic                         clip_ready,
	output logic signed [COORD_BITS-1:0] clipped_x,
	output logic signed [COORD_BITS-1:0] clipped_y,
	output logic                         ring_end,
	output logic                         ring_empty
);

	logic signed [COORD_BITS-1:0] left_q, bottom_q, right_q, top_q;
	logic signed [COORD_BITS-1:0] stage_bnd [NUM_CELLS];
	link_ctl_t                    lk_ctl    [NUM_CELLS+1];
	logic signed [COORD_BITS-1:0] lk_x      [NUM_CELLS+1];
	logic signed [COORD_BITS-1:0] lk_y      [NUM_CELLS+1];
	logic                         lk_rdy    [NUM_CELLS+1];

	// window registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			bottom_q <= '0;
			right_q  <= '0;
			top_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stage_bnd[EDGE_LEFT]   = left_q;
	assign stage_bnd[EDGE_RIGHT]  = right_q;
	assign stage_bnd[EDGE_BOTTOM] = bottom_q;
	assign stage_bnd[EDGE_TOP]    = top_q;

	rpc_feeder #(.C(COORD_BITS)) u_feeder (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.polygon_end  (polygon_end),
		.dn_ctl       (lk_ctl[0]),
		.dn_x         (lk_x[0]),
		.dn_y         (lk_y[0]),
		.dn_ready     (lk_rdy[0])
	);

	// chain of half-plane cells
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		rpc_clip_cell #(.C(COORD_BITS), .EDGE_SEL(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bnd      (stage_bnd[k]),
			.up_ctl   (lk_ctl[k]),
			.up_x     (lk_x[k]),
			.up_y     (lk_y[k]),
			.up_ready (lk_rdy[k]),
			.dn_ctl   (lk_ctl[k+1]),
			.dn_x     (lk_x[k+1]),
			.dn_y     (lk_y[k+1]),
			.dn_ready (lk_rdy[k+1])
		);
	end

	rpc_emitter #(.C(COORD_BITS)) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_ctl     (lk_ctl[NUM_CELLS]),
		.up_x       (lk_x[NUM_CELLS]),
		.up_y       (lk_y[NUM_CELLS]),
		.up_ready   (lk_rdy[NUM_CELLS]),
		.clip_valid (clip_valid),
		.clip_ready (clip_ready),
		.clipped_x  (clipped_x),
		.clipped_y  (clipped_y),
		.ring_end   (ring_end),
		.ring_empty (ring_empty)
	);

	// an empty result is always the last one of its ring
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && ring_empty |-> ring_end)
		else $error("empty result without end mark");

	// an empty result carries zero coordinates
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && ring_empty |-> (clipped_x == '0) && (clipped_y == '0))
		else $error("empty result with nonzero coordinates");

	// the feeder is busy right after the last vertex of a polygon
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_ready && polygon_end |=> !vertex_ready)
		else $error("vertex taken while closing a polygon");

endmodule

@@ design/rpc_interp.sv @@
`timescale 1ns / 1ps

module rpc_interp import rpc_pkg::*; #(
	parameter int unsigned C = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [C-1:0] a1,
	input  logic signed [C-1:0] a2,
	input  logic signed [C-1:0] n1,
	input  logic signed [C-1:0] n2,
	input  logic signed [C-1:0] bnd,
	output logic                done,
	output logic [C-1:0]        result
);

	localparam int unsigned CW = $clog2(C + 1);
	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_MUL  = 3'd1;
	localparam logic [2:0] P_PREP = 3'd2;
	localparam logic [2:0] P_DIV  = 3'd3;
	localparam logic [2:0] P_DONE = 3'd4;

	logic [2:0]          phase_q;
	logic [CW-1:0]       cnt_q;
	logic signed [C:0]   dv, num, den;
	logic [C:0]          dv_abs, num_abs, den_abs;
	logic [C-1:0]        a_q, b_q, d_q, base_q, lo_q, q_q, q_eff;
	logic                neg_q, dz_q;
	logic [2*C-1:0]      prod_q;
	logic [C:0]          rem_q;
	logic [2*C+1:0]      n_full;
	logic [C+1:0]        t, dd, t_sub;
	logic                ge;

	// signed differences and magnitudes
	assign dv  = {a2[C-1], a2} - {a1[C-1], a1};
	assign num = {bnd[C-1], bnd} - {n1[C-1], n1};
	assign den = {n2[C-1], n2} - {n1[C-1], n1};
	assign dv_abs  = dv[C]  ? (~dv + 1'b1)  : dv;
	assign num_abs = num[C] ? (~num + 1'b1) : num;
	assign den_abs = den[C] ? (~den + 1'b1) : den;

	// rounding numerator 2ab + d, one restoring divide step
	assign n_full = {1'b0, prod_q, 1'b0} + {{(C+2){1'b0}}, d_q};
	assign t      = {rem_q, lo_q[C-1]};
	assign dd     = {1'b0, d_q, 1'b0};
	assign ge     = (t >= dd);
	assign t_sub  = t - dd;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
		end else if (start) begin
			phase_q <= P_MUL;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				P_MUL: begin
					if (cnt_q == CW'(C - 1)) begin
						phase_q <= P_PREP;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				P_PREP: phase_q <= P_DIV;
				P_DIV: begin
					if (cnt_q == CW'(C - 1)) begin
						phase_q <= P_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: shift-add multiply, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= dv_abs[C-1:0];
			b_q    <= num_abs[C-1:0];
			d_q    <= den_abs[C-1:0];
			neg_q  <= dv[C] ^ num[C] ^ den[C];
			dz_q   <= (den == '0);
			base_q <= a1;
			prod_q <= '0;
			q_q    <= '0;
		end else begin
			case (phase_q)
				P_MUL: begin
					prod_q <= {prod_q[2*C-2:0], 1'b0} + (b_q[C-1] ? {{C{1'b0}}, a_q} : '0);
					b_q    <= {b_q[C-2:0], 1'b0};
				end
				P_PREP: begin
					rem_q <= n_full[2*C:C];
					lo_q  <= n_full[C-1:0];
				end
				P_DIV: begin
					rem_q <= ge ? t_sub[C:0] : t[C:0];
					lo_q  <= {lo_q[C-2:0], 1'b0};
					q_q   <= {q_q[C-2:0], ge};
				end
				default: ;
			endcase
		end
	end

	assign q_eff  = dz_q ? '0 : q_q;
	assign done   = (phase_q == P_DONE);
	assign result = neg_q ? (base_q - q_eff) : (base_q + q_eff);

endmodule

@@ design/rpc_feeder.sv @@
`timescale 1ns / 1ps

module rpc_feeder import rpc_pkg::*; #(
	parameter int unsigned C = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vertex_valid,
	output logic                vertex_ready,
	input  logic signed [C-1:0] vertex_x,
	input  logic signed [C-1:0] vertex_y,
	input  logic                polygon_end,
	output link_ctl_t           dn_ctl,
	output logic signed [C-1:0] dn_x,
	output logic signed [C-1:0] dn_y,
	input  logic                dn_ready
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_P0   = 3'd1;
	localparam logic [2:0] F_P1   = 3'd2;
	localparam logic [2:0] F_V    = 3'd3;
	localparam logic [2:0] F_T    = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          count_q;
	logic                last_q, dn_valid_q, dn_close_q, slot_free, take;
	logic signed [C-1:0] p0_x_q, p0_y_q, p1_x_q, p1_y_q, v_x_q, v_y_q;

	assign vertex_ready = (state_q == F_IDLE);
	assign take         = vertex_valid && vertex_ready;
	assign slot_free    = !dn_valid_q || dn_ready;
	assign dn_ctl       = '{valid: dn_valid_q, close: dn_close_q};

	// sequencer: the first two vertices wait until a third one arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			count_q    <= '0;
			last_q     <= 1'b0;
			dn_valid_q <= 1'b0;
		end else begin
			if (slot_free) dn_valid_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (take) begin
						last_q <= polygon_end;
						if (count_q < 2'd2) begin
							if (polygon_end) state_q <= F_T;
							else count_q <= count_q + 1'b1;
						end else begin
							state_q <= (count_q == 2'd2) ? F_P0 : F_V;
							count_q <= 2'd3;
						end
					end
				end
				F_P0: if (slot_free) begin
					dn_valid_q <= 1'b1;
					state_q    <= F_P1;
				end
				F_P1: if (slot_free) begin
					dn_valid_q <= 1'b1;
					state_q    <= F_V;
				end
				F_V: if (slot_free) begin
					dn_valid_q <= 1'b1;
					state_q    <= last_q ? F_T : F_IDLE;
				end
				F_T: if (slot_free) begin
					dn_valid_q <= 1'b1;
					count_q    <= '0;
					state_q    <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// vertex storage and output register
	always_ff @(posedge clk) begin
		if (take) begin
			v_x_q <= vertex_x;
			v_y_q <= vertex_y;
			if (count_q == 2'd0) begin
				p0_x_q <= vertex_x;
				p0_y_q <= vertex_y;
			end
			if (count_q == 2'd1) begin
				p1_x_q <= vertex_x;
				p1_y_q <= vertex_y;
			end
		end
		if (slot_free) begin
			case (state_q)
				F_P0: begin
					dn_x <= p0_x_q; dn_y <= p0_y_q; dn_close_q <= 1'b0;
				end
				F_P1: begin
					dn_x <= p1_x_q; dn_y <= p1_y_q; dn_close_q <= 1'b0;
				end
				F_V: begin
					dn_x <= v_x_q; dn_y <= v_y_q; dn_close_q <= 1'b0;
				end
				F_T: dn_close_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ design/rpc_clip_cell.sv @@
`timescale 1ns / 1ps

module rpc_clip_cell import rpc_pkg::*; #(
	parameter int unsigned C        = 32,
	parameter int unsigned EDGE_SEL = EDGE_LEFT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [C-1:0] bnd,
	input  link_ctl_t           up_ctl,
	input  logic signed [C-1:0] up_x,
	input  logic signed [C-1:0] up_y,
	output logic                up_ready,
	output link_ctl_t           dn_ctl,
	output logic signed [C-1:0] dn_x,
	output logic signed [C-1:0] dn_y,
	input  logic                dn_ready
);

	localparam bit USE_Y   = (EDGE_SEL == EDGE_BOTTOM) || (EDGE_SEL == EDGE_TOP);
	localparam bit KEEP_HI = (EDGE_SEL == EDGE_LEFT) || (EDGE_SEL == EDGE_BOTTOM);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EDGE   = 3'd1;
	localparam logic [2:0] S_PUT_P  = 3'd2;
	localparam logic [2:0] S_WAIT_I = 3'd3;
	localparam logic [2:0] S_PUT_T  = 3'd4;

	logic [2:0]          state_q, state_d, after;
	logic                seen_q, closing_q, dn_valid_q, dn_close_q;
	logic                slot_free, take, in1, in2, start, ip_done, load;
	logic                ld_close;
	logic signed [C-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [C-1:0] p_x_q, p_y_q, c_x_q, c_y_q, ld_x, ld_y, p_u, c_u;
	logic [C-1:0]        ip_res;

	// half-plane test of both edge ends, boundary counts as inside
	assign p_u = USE_Y ? p_y_q : p_x_q;
	assign c_u = USE_Y ? c_y_q : c_x_q;
	assign in1 = KEEP_HI ? (p_u >= bnd) : (p_u <= bnd);
	assign in2 = KEEP_HI ? (c_u >= bnd) : (c_u <= bnd);

	rpc_interp #(.C(C)) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.a1     (USE_Y ? p_x_q : p_y_q),
		.a2     (USE_Y ? c_x_q : c_y_q),
		.n1     (p_u),
		.n2     (c_u),
		.bnd    (bnd),
		.done   (ip_done),
		.result (ip_res)
	);

	assign up_ready  = (state_q == S_IDLE);
	assign take      = up_ctl.valid && up_ready;
	assign slot_free = !dn_valid_q || dn_ready;
	assign after     = closing_q ? S_PUT_T : S_IDLE;
	assign dn_ctl    = '{valid: dn_valid_q, close: dn_close_q};

	// edge sequencing: inside start point, then crossing point
	always_comb begin
		state_d  = state_q;
		load     = 1'b0;
		ld_x     = p_x_q;
		ld_y     = p_y_q;
		ld_close = 1'b0;
		start    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (take && (seen_q || up_ctl.close)) begin
					state_d = seen_q ? S_EDGE : S_PUT_T;
				end
			end
			S_EDGE: begin
				if (in1) begin
					state_d = S_PUT_P;
				end else if (in2) begin
					start   = 1'b1;
					state_d = S_WAIT_I;
				end else begin
					state_d = after;
				end
			end
			S_PUT_P: begin
				if (slot_free) begin
					load = 1'b1;
					if (!in2) begin
						start   = 1'b1;
						state_d = S_WAIT_I;
					end else begin
						state_d = after;
					end
				end
			end
			S_WAIT_I: begin
				if (ip_done && slot_free) begin
					load    = 1'b1;
					ld_x    = USE_Y ? ip_res : bnd;
					ld_y    = USE_Y ? bnd : ip_res;
					state_d = after;
				end
			end
			S_PUT_T: begin
				if (slot_free) begin
					load     = 1'b1;
					ld_close = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			seen_q     <= 1'b0;
			closing_q  <= 1'b0;
			dn_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				closing_q <= up_ctl.close;
				if (!up_ctl.close) seen_q <= 1'b1;
			end
			if (state_q == S_PUT_T && slot_free) seen_q <= 1'b0;
			if (load) dn_valid_q <= 1'b1;
			else if (dn_ready) dn_valid_q <= 1'b0;
		end
	end

	// ring registers and output register
	always_ff @(posedge clk) begin
		if (take) begin
			if (up_ctl.close) begin
				p_x_q <= prev_x_q; p_y_q <= prev_y_q;
				c_x_q <= first_x_q; c_y_q <= first_y_q;
			end else begin
				p_x_q <= prev_x_q; p_y_q <= prev_y_q;
				c_x_q <= up_x; c_y_q <= up_y;
				prev_x_q <= up_x; prev_y_q <= up_y;
				if (!seen_q) begin
					first_x_q <= up_x; first_y_q <= up_y;
				end
			end
		end
		if (load) begin
			dn_x       <= ld_x;
			dn_y       <= ld_y;
			dn_close_q <= ld_close;
		end
	end

endmodule

@@ design/rpc_emitter.sv @@
`timescale 1ns / 1ps

module rpc_emitter import rpc_pkg::*; #(
	parameter int unsigned C = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  link_ctl_t           up_ctl,
	input  logic signed [C-1:0] up_x,
	input  logic signed [C-1:0] up_y,
	output logic                up_ready,
	output logic                clip_valid,
	input  logic                clip_ready,
	output logic signed [C-1:0] clipped_x,
	output logic signed [C-1:0] clipped_y,
	output logic                ring_end,
	output logic                ring_empty
);

	logic                has_q, take, load;
	logic signed [C-1:0] held_x_q, held_y_q;

	assign up_ready = !clip_valid || clip_ready;
	assign take     = up_ctl.valid && up_ready;
	assign load     = take && (up_ctl.close || has_q);

	// one vertex held back so the last one can carry the end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q      <= 1'b0;
			clip_valid <= 1'b0;
		end else begin
			if (take) has_q <= !up_ctl.close;
			if (load) clip_valid <= 1'b1;
			else if (clip_ready) clip_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !up_ctl.close) begin
			held_x_q <= up_x;
			held_y_q <= up_y;
		end
		if (load) begin
			clipped_x  <= has_q ? held_x_q : '0;
			clipped_y  <= has_q ? held_y_q : '0;
			ring_end   <= up_ctl.close;
			ring_empty <= !has_q;
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rpc_pkg::*;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} vertex_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        fin;
		logic        empty;
	} clip_res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_idx_t           cfg_index;
	logic signed [31:0] cfg_data;
	logic               vertex_valid;
	logic               vertex_ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic               polygon_end;
	logic               clip_valid;
	logic               clip_ready;
	logic signed [31:0] clipped_x;
	logic signed [31:0] clipped_y;
	logic               ring_end;
	logic               ring_empty;

	rect_polygon_clip #(.COORD_BITS(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.vertex_valid(vertex_valid), .vertex_ready(vertex_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .polygon_end(polygon_end),
		.clip_valid(clip_valid), .clip_ready(clip_ready),
		.clipped_x(clipped_x), .clipped_y(clipped_y),
		.ring_end(ring_end), .ring_empty(ring_empty)
	);

	// clock, 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	vertex_t   vertex_queue[$];
	clip_res_t clipped_queue[$];
	int        mismatches = 0;
	bit        long_hold_req = 0;

	// window copy used by the clipping predictor
	longint win_left = 0, win_bottom = 0, win_right = 0, win_top = 0;

	// per-cell predictor state
	longint cell_fx[4], cell_fy[4], cell_px[4], cell_py[4];
	int     cell_seen[4];
	int     vertex_count;
	bit     have_held;
	longint held_x, held_y;
	longint next_x[$], next_y[$];

	function automatic void push_result(longint x, longint y, logic fin, logic empty);
		clip_res_t r;
		r.x = x[31:0];
		r.y = y[31:0];
		r.fin = fin;
		r.empty = empty;
		clipped_queue.insert(clipped_queue.size(), r);
	endfunction

	function automatic void clear_ring();
		for (int k = 0; k < NUM_CELLS; k++) begin
			cell_fx[k] = 0; cell_fy[k] = 0; cell_px[k] = 0; cell_py[k] = 0;
			cell_seen[k] = 0;
		end
		vertex_count = 0;
		have_held = 0;
		held_x = 0;
		held_y = 0;
	endfunction

	// a1 + (a2-a1)*num/den, rounded half away from zero
	function automatic longint cross_coord(longint a1, longint a2, longint num, longint den);
		longint       dv;
		logic [127:0] ma, mb, md, q;
		bit           neg;
		dv = a2 - a1;
		if (dv == 0 || num == 0 || den == 0)
			return a1;
		neg = (dv < 0) != ((num < 0) != (den < 0));
		ma = (dv < 0) ? -dv : dv;
		mb = (num < 0) ? -num : num;
		md = (den < 0) ? -den : den;
		q = (2 * ma * mb + md) / (2 * md);
		return neg ? a1 - longint'(q[63:0]) : a1 + longint'(q[63:0]);
	endfunction

	function automatic bit in_half(int k, longint x, longint y);
		case (k)
			EDGE_LEFT:   return x >= win_left;
			EDGE_RIGHT:  return x <= win_right;
			EDGE_BOTTOM: return y >= win_bottom;
			default:     return y <= win_top;
		endcase
	endfunction

	// output of cell k goes to the next cell's list or to the held output vertex
	function automatic void pass_on(int k, longint x, longint y);
		if (k == NUM_CELLS - 1) begin
			if (have_held)
				push_result(held_x, held_y, 1'b0, 1'b0);
			held_x = x;
			held_y = y;
			have_held = 1;
		end else begin
			next_x.insert(next_x.size(), x);
			next_y.insert(next_y.size(), y);
		end
	endfunction

	function automatic void clip_segment(int k, longint x1, longint y1, longint x2, longint y2);
		bit     in1, in2;
		longint ix, iy;
		in1 = in_half(k, x1, y1);
		in2 = in_half(k, x2, y2);
		if (!in1 && !in2)
			return;
		if (in1)
			pass_on(k, x1, y1);
		if (in1 && in2)
			return;
		case (k)
			EDGE_LEFT: begin
				ix = win_left;
				iy = cross_coord(y1, y2, win_left - x1, x2 - x1);
			end
			EDGE_RIGHT: begin
				ix = win_right;
				iy = cross_coord(y1, y2, win_right - x1, x2 - x1);
			end
			EDGE_BOTTOM: begin
				iy = win_bottom;
				ix = cross_coord(x1, x2, win_bottom - y1, y2 - y1);
			end
			default: begin
				iy = win_top;
				ix = cross_coord(x1, x2, win_top - y1, y2 - y1);
			end
		endcase
		pass_on(k, ix, iy);
	endfunction

	function automatic void cell_take(int k, longint x, longint y);
		if (cell_seen[k] == 0) begin
			cell_fx[k] = x; cell_fy[k] = y;
			cell_px[k] = x; cell_py[k] = y;
			cell_seen[k] = 1;
			return;
		end
		clip_segment(k, cell_px[k], cell_py[k], x, y);
		cell_px[k] = x;
		cell_py[k] = y;
		cell_seen[k] = 2;
	endfunction

	// expected clipped vertices caused by one accepted input vertex
	function automatic void predict_clip(vertex_t v);
		longint x, y;
		longint cx[$], cy[$];
		x = longint'($signed(v.x));
		y = longint'($signed(v.y));
		if (vertex_count + 1 < 3) begin
			if (v.last) begin
				push_result(0, 0, 1'b1, 1'b1);
				clear_ring();
				return;
			end
			if (vertex_count == 0) begin
				cell_fx[0] = x; cell_fy[0] = y;
				cell_seen[0] = 1;
			end
			cell_px[0] = x;
			cell_py[0] = y;
			vertex_count++;
			return;
		end
		next_x.delete();
		next_y.delete();
		if (vertex_count + 1 == 3) begin
			clip_segment(0, cell_fx[0], cell_fy[0], cell_px[0], cell_py[0]);
			cell_seen[0] = 2;
		end
		cell_take(0, x, y);
		if (vertex_count < 3)
			vertex_count++;
		if (v.last && cell_seen[0] != 0)
			clip_segment(0, cell_px[0], cell_py[0], cell_fx[0], cell_fy[0]);
		// cascade through the remaining cells, closing each ring on the last vertex
		for (int k = 1; k < NUM_CELLS; k++) begin
			cx = next_x;
			cy = next_y;
			next_x.delete();
			next_y.delete();
			foreach (cx[i])
				cell_take(k, cx[i], cy[i]);
			if (v.last && cell_seen[k] != 0)
				clip_segment(k, cell_px[k], cell_py[k], cell_fx[k], cell_fy[k]);
		end
		if (!v.last)
			return;
		if (have_held)
			push_result(held_x, held_y, 1'b1, 1'b0);
		else
			push_result(0, 0, 1'b1, 1'b1);
		clear_ring();
	endfunction

	// vertex driver: bursts with random gaps
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		vertex_t v;
		bit      nv;
		if (!arst_n) begin
			vertex_valid <= 1'b0;
			vertex_x <= '0;
			vertex_y <= '0;
			polygon_end <= 1'b0;
		end else if (!(vertex_valid && !vertex_ready)) begin
			if (vertex_valid) begin
				v.x = vertex_x;
				v.y = vertex_y;
				v.last = polygon_end;
				predict_clip(v);
			end
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (vertex_queue.size() > 0) begin
				v = vertex_queue.pop_front();
				nv = 1'b1;
				vertex_x <= v.x;
				vertex_y <= v.y;
				polygon_end <= v.last;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end
			end
			vertex_valid <= nv;
		end
	end

	// result receiver: stall pattern plus one long hold-off
	int  hold_cnt = 0;
	int  run_left = 0;
	bit  run_free = 1;
	bit  long_hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			clip_ready <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1;
			hold_cnt = 2000;
			clip_ready <= 1'b0;
		end else begin
			if (run_left == 0) begin
				run_left = $urandom_range(5, 60);
				run_free = $urandom_range(0, 2) == 0;
			end
			run_left--;
			clip_ready <= run_free ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	// result monitor
	always @(posedge clk) begin
		clip_res_t e;
		if (arst_n && clip_valid && clip_ready) begin
			if (clipped_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: x=%0d y=%0d end=%0b empty=%0b",
						clipped_x, clipped_y, ring_end, ring_empty);
			end else begin
				e = clipped_queue.pop_front();
				if (clipped_x !== e.x || clipped_y !== e.y || ring_end !== e.fin ||
						ring_empty !== e.empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%0d y=%0d end=%0b empty=%0b, got x=%0d y=%0d end=%0b empty=%0b",
							$signed(e.x), $signed(e.y), e.fin, e.empty,
							clipped_x, clipped_y, ring_end, ring_empty);
				end
			end
		end
	end

	task automatic set_window(longint l, longint b, longint r, longint t);
		longint vals[4];
		cfg_idx_t idx[4];
		vals = '{l, b, r, t};
		idx = '{REG_LEFT, REG_BOTTOM, REG_RIGHT, REG_TOP};
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i][31:0];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_LEFT:   win_left = longint'($signed(vals[i][31:0]));
				REG_BOTTOM: win_bottom = longint'($signed(vals[i][31:0]));
				REG_RIGHT:  win_right = longint'($signed(vals[i][31:0]));
				default:    win_top = longint'($signed(vals[i][31:0]));
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic add_vertex(longint x, longint y, bit last);
		vertex_t v;
		v.x = x[31:0];
		v.y = y[31:0];
		v.last = last;
		vertex_queue.insert(vertex_queue.size(), v);
	endtask

	function automatic longint pick_coord(longint lo, longint hi);
		longint span;
		int     sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return longint'($signed($urandom));
		if (sel <= 2)
			return ($urandom_range(0, 1) == 0) ? lo : hi;
		span = (hi > lo) ? hi - lo : lo - hi;
		if (span > 64'd1 << 30)
			span = 64'd1 << 30;
		if (span < 8)
			span = 8;
		return ((lo < hi) ? lo : hi) - span / 4 + longint'($urandom_range(0, 32'(span + span / 2)));
	endfunction

	task automatic add_random_polygons(int count);
		int added, n;
		added = 0;
		while (added < count) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			for (int i = 0; i < n; i++)
				add_vertex(pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
					i == n - 1);
			added += n;
		end
	endtask

	// wait for the sender to drain and every expected result to arrive
	task automatic drain();
		do @(posedge clk); while (vertex_queue.size() > 0 || vertex_valid ||
			clipped_queue.size() > 0);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		longint a, b;
		clear_ring();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LEFT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset window: a single point at the origin
		add_vertex(-5, -5, 0); add_vertex(5, -5, 0); add_vertex(0, 5, 1);
		add_vertex(0, 0, 0); add_vertex(3, 0, 0); add_vertex(0, 3, 1);
		add_random_polygons(20);
		drain();

		// directed shapes in a normal window
		set_window(-1000, -800, 1000, 900);
		add_vertex(10, 10, 1);
		add_vertex(10, 10, 0); add_vertex(20, 30, 1);
		add_vertex(0, 0, 0); add_vertex(100, 0, 0); add_vertex(50, 80, 1);
		add_vertex(-3000, -3000, 0); add_vertex(3000, -3000, 0);
		add_vertex(3000, 3000, 0); add_vertex(-3000, 3001, 1);
		add_vertex(2000, 0, 0); add_vertex(3000, 0, 0); add_vertex(2500, 500, 1);
		add_vertex(-1000, -800, 0); add_vertex(1000, -800, 0); add_vertex(1000, 900, 1);
		add_vertex(32'h80000000, 32'h80000000, 0); add_vertex(32'h7fffffff, 32'h80000000, 0);
		add_vertex(32'h7fffffff, 32'h7fffffff, 0); add_vertex(32'h80000000, 32'h7fffffff, 1);
		add_vertex(-1500, 0, 0); add_vertex(0, -1333, 0); add_vertex(1501, 7, 1);
		add_random_polygons(40);
		drain();

		// full-range window, with a long stall on the result side
		set_window(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		long_hold_req = 1;
		add_random_polygons(60);
		drain();

		// inverted window
		set_window(500, 500, -500, -500);
		add_random_polygons(40);
		drain();

		// random window
		a = longint'($signed($urandom));
		b = longint'($signed($urandom));
		set_window(a < b ? a : b, -100000, a < b ? b : a, 100000);
		add_random_polygons(60);
		drain();

		// tiny window, many crossings
		set_window(-3, -7, 4, 9);
		add_random_polygons(60);
		drain();

		// wide window with random full-range content
		set_window(-(64'd1 << 30), -(64'd1 << 29), 64'd1 << 30, 64'd1 << 29);
		add_random_polygons(40);
		drain();

		if (mismatches == 0)
			$display("rect_polygon_clip test passed");
		else
			$display("rect_polygon_clip test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("rect_polygon_clip test failed");
		$finish;
	end

endmodule
